// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int STATUS_W       = 3;
  localparam int OUT_IDX_W      = 8;
  localparam int OUT_CNT_W      = 9;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE     = 2'd0,
    REG_BLOCK_SIZE    = 2'd1,
    REG_BLOCK_COUNT   = 2'd2,
    REG_BUFFER_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_BAD_ADDR  = 3'd2,
    STAT_NOT_ALLOC = 3'd3,
    STAT_INIT_REJ  = 3'd4,
    STAT_NOT_INIT  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_CHK,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ALLOC_MUL,
    ST_ALLOC_ADD,
    ST_DIV,
    ST_FREE_CHK,
    ST_FREE_UPD,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/bba_map_ram.sv =====
module bba_map_ram #(
  parameter int DEPTH  = 32,
  parameter int AW     = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bba_divider.sv =====
module bba_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bba_pkg::ADDR_W-1:0] dividend,
  input  logic [bba_pkg::SIZE_W-1:0] divisor,
  output logic                      done,
  output logic [bba_pkg::ADDR_W-1:0] quotient,
  output logic [bba_pkg::SIZE_W-1:0] remainder
);

  import bba_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   rem_diff;
  logic              rem_ge;

  // One quotient bit per cycle, restoring form.
  assign rem_sh   = {remainder, quotient[ADDR_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[ADDR_W-2:0], rem_ge};
      remainder <= rem_ge ? rem_diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
    end
  end

endmodule

// ===== rtl/bitmap_block_allocator_core.sv =====
// Fixed-size block allocator. One bit per block lives in an 8-bit-wide map
// RAM (ceil(MAX_BLOCKS/8) words, registered read). An initialize command
// checks the base address, block size, block count and buffer length,
// latches them and clears the map with a sweep that writes one word a cycle.
// Allocate scans the map from word 0; each word read is issued in
// ST_SCAN_RD and its registered data tested in ST_SCAN_CHK, until the first
// word with a free block. When the pool is full, every word up to the block
// count is read. Free runs address - base through a bit-serial divider to
// get the index and the alignment check, then reads one map word and
// rewrites it when the block was allocated. The unused command, an init
// that fails its register checks, a null free and an alloc or free on a
// pool that is not initialized go straight to the result; an init turned
// down for a short buffer is rejected after the size product is formed.
// One command is in flight at a time; in_stall is high while it runs. The
// result sits in an output register, so the next command can be taken
// while the previous result still waits for its transfer. Configuration
// writes take effect only at the next successful initialize.
module bitmap_block_allocator_core #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]    cfg_data,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [bba_pkg::ADDR_W-1:0]    address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bba_pkg::STATUS_W-1:0]  status,
  output logic [bba_pkg::ADDR_W-1:0]    block_address,
  output logic [bba_pkg::OUT_IDX_W-1:0] block_index,
  output logic [bba_pkg::OUT_CNT_W-1:0] used_count,
  output logic [bba_pkg::OUT_CNT_W-1:0] peak_count
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + 7) / 8;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = WADDR_W + 3;           // block index
  localparam int CMP_W     = WADDR_W + 4;           // word pointer * 8, with headroom
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W    = IDX_W + SIZE_W;

  // configuration registers
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] blk_bytes;
  logic [SIZE_W-1:0] blk_total;
  logic [SIZE_W-1:0] buffer_length;

  // pool state
  logic [ADDR_W-1:0] lat_base;
  logic [SIZE_W-1:0] lat_size;
  logic [CNT_W-1:0]  lat_count;
  logic              pool_ready;
  logic [CNT_W-1:0]  used_blocks;
  logic [CNT_W-1:0]  peak_blocks;

  state_t state, state_next;

  // working registers
  logic [WADDR_W:0]  word_ptr;
  logic [ADDR_W-1:0] need_prod;
  logic [IDX_W-1:0]  blk_idx;
  logic [PROD_W-1:0] prod;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [IDX_W-1:0]  res_idx;

  // map RAM ports
  logic               map_we;
  logic [WADDR_W-1:0] map_waddr;
  logic [7:0]         map_wdata;
  logic               map_re;
  logic [WADDR_W-1:0] map_raddr;
  logic [7:0]         map_rdata;

  // divider
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [SIZE_W-1:0] div_rem;

  // decode
  logic              accept;
  logic              init_bad;
  logic              init_short;
  logic [CMP_W-1:0]  word_base;
  logic [CMP_W-1:0]  lat_count_ext;
  logic              scan_end;
  logic              scan_hit;
  logic [2:0]        scan_bit;
  logic              free_bad;
  logic [2:0]        free_bit;
  logic              free_set;
  logic              last_clear;
  logic              out_free;
  logic [CNT_W-1:0]  used_inc;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign init_bad = (pool_base == '0) || (blk_bytes == '0) || (blk_total == '0) ||
                    (blk_total > SIZE_W'(MAX_BLOCKS));
  assign init_short = ({16'd0, buffer_length} <
                       need_prod + ADDR_W'((17'(blk_total) + 17'd7) >> 3));

  assign word_base     = {word_ptr, 3'b000};
  assign lat_count_ext = CMP_W'(lat_count);
  assign scan_end      = (word_base >= lat_count_ext);
  assign last_clear    = (word_ptr == (WADDR_W + 1)'(MAP_WORDS - 1));
  assign used_inc      = used_blocks + 1'b1;

  // Lowest clear bit of the fetched word that is still inside the pool.
  always_comb begin
    logic [CMP_W-1:0] cand;
    scan_hit = 1'b0;
    scan_bit = '0;
    cand     = '0;
    for (int b = 7; b >= 0; b--) begin
      cand = word_base + CMP_W'(b);
      if (!map_rdata[b] && (cand < lat_count_ext)) begin
        scan_hit = 1'b1;
        scan_bit = 3'(b);
      end
    end
  end

  // Free is out of range on a remainder or an untruncated index past the pool.
  assign free_bad = (div_rem != '0) || (div_quo >= ADDR_W'(lat_count));
  assign free_bit = blk_idx[2:0];
  assign free_set = map_rdata[free_bit];

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WADDR_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wdata),
    .rd_en   (map_re),
    .rd_addr (map_raddr),
    .rd_data (map_rdata)
  );

  bba_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (address - lat_base),
    .divisor   (lat_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, map RAM control and divider start.
  always_comb begin
    state_next = state;
    map_we     = 1'b0;
    map_waddr  = word_ptr[WADDR_W-1:0];
    map_wdata  = '0;
    map_re     = 1'b0;
    map_raddr  = word_ptr[WADDR_W-1:0];
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INIT: begin
              state_next = init_bad ? ST_DONE : ST_INIT_MUL;
            end
            CMD_ALLOC: begin
              state_next = pool_ready ? ST_SCAN_RD : ST_DONE;
            end
            CMD_FREE: begin
              if (pool_ready && (address != '0)) begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_INIT_MUL: begin
        state_next = ST_INIT_CHK;
      end
      ST_INIT_CHK: begin
        state_next = init_short ? ST_DONE : ST_CLEAR;
      end
      ST_CLEAR: begin
        map_we = 1'b1;
        if (last_clear) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_RD: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end else begin
          map_re     = 1'b1;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          map_we     = 1'b1;
          map_wdata  = map_rdata | (8'b1 << scan_bit);
          state_next = ST_ALLOC_MUL;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_ALLOC_MUL: begin
        state_next = ST_ALLOC_ADD;
      end
      ST_ALLOC_ADD: begin
        state_next = ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FREE_CHK;
        end
      end
      ST_FREE_CHK: begin
        if (free_bad) begin
          state_next = ST_DONE;
        end else begin
          map_re     = 1'b1;
          map_raddr  = div_quo[IDX_W-1:3];
          state_next = ST_FREE_UPD;
        end
      end
      ST_FREE_UPD: begin
        map_waddr = blk_idx[IDX_W-1:3];
        if (free_set) begin
          map_we    = 1'b1;
          map_wdata = map_rdata & ~(8'b1 << free_bit);
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers: the user must write them only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base     <= '0;
      blk_bytes     <= '0;
      blk_total     <= '0;
      buffer_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POOL_BASE:     pool_base     <= cfg_data;
        REG_BLOCK_SIZE:    blk_bytes     <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_COUNT:   blk_total     <= cfg_data[SIZE_W-1:0];
        REG_BUFFER_LENGTH: buffer_length <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pool state and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_base    <= '0;
      lat_size    <= '0;
      lat_count   <= '0;
      pool_ready  <= 1'b0;
      used_blocks <= '0;
      peak_blocks <= '0;
    end else begin
      case (state)
        ST_INIT_CHK: begin
          if (!init_short) begin
            lat_base    <= pool_base;
            lat_size    <= blk_bytes;
            lat_count   <= blk_total[CNT_W-1:0];
            pool_ready  <= 1'b1;
            used_blocks <= '0;
            peak_blocks <= '0;
          end
        end
        ST_SCAN_CHK: begin
          if (scan_hit) begin
            used_blocks <= used_inc;
            if (used_inc > peak_blocks) begin
              peak_blocks <= used_inc;
            end
          end
        end
        ST_FREE_UPD: begin
          if (free_set && (used_blocks != '0)) begin
            used_blocks <= used_blocks - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and the pending result.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        word_ptr <= '0;
        res_addr <= '0;
        res_idx  <= '0;
        if (accept) begin
          case (cmd)
            CMD_INIT:  res_status <= init_bad ? STAT_INIT_REJ : STAT_OK;
            CMD_ALLOC: res_status <= pool_ready ? STAT_OK : STAT_NOT_INIT;
            CMD_FREE: begin
              if (!pool_ready) begin
                res_status <= STAT_NOT_INIT;
              end else if (address == '0) begin
                res_status <= STAT_BAD_ADDR;
              end else begin
                res_status <= STAT_OK;
              end
            end
            default:   res_status <= STAT_INIT_REJ;
          endcase
        end
      end
      ST_INIT_MUL: begin
        need_prod <= blk_bytes * blk_total;
      end
      ST_INIT_CHK: begin
        if (init_short) begin
          res_status <= STAT_INIT_REJ;
        end
      end
      ST_CLEAR: begin
        word_ptr <= word_ptr + 1'b1;
      end
      ST_SCAN_RD: begin
        if (scan_end) begin
          res_status <= STAT_FULL;
        end
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          blk_idx <= {word_ptr[WADDR_W-1:0], scan_bit};
        end else begin
          word_ptr <= word_ptr + 1'b1;
        end
      end
      ST_ALLOC_MUL: begin
        prod <= blk_idx * lat_size;
      end
      ST_ALLOC_ADD: begin
        res_addr <= lat_base + ADDR_W'(prod);
        res_idx  <= blk_idx;
      end
      ST_FREE_CHK: begin
        blk_idx <= div_quo[IDX_W-1:0];
        if (free_bad) begin
          res_status <= STAT_BAD_ADDR;
        end
      end
      ST_FREE_UPD: begin
        if (free_set) begin
          res_idx <= blk_idx;
        end else begin
          res_status <= STAT_NOT_ALLOC;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold until the transfer, load when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      status        <= res_status;
      block_address <= res_addr;
      block_index   <= OUT_IDX_W'(res_idx);
      used_count    <= OUT_CNT_W'(used_blocks);
      peak_count    <= OUT_CNT_W'(peak_blocks);
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bba_pkg::*;

  localparam int POOL_MAX = MAX_BLOCKS_DEF;

  // One reply of the allocator, as the result channel carries it.
  typedef struct packed {
    status_t         code;
    logic [31:0]     blk_addr;
    logic [7:0]      blk_idx;
    logic [8:0]      used;
    logic [8:0]      peak;
  } reply_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Configuration port
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  // Command channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd      = '0;
  logic [ADDR_W-1:0]  address  = '0;

  // Result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [ADDR_W-1:0]    block_address;
  logic [OUT_IDX_W-1:0] block_index;
  logic [OUT_CNT_W-1:0] used_count;
  logic [OUT_CNT_W-1:0] peak_count;

  bitmap_block_allocator_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .address       (address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .block_address (block_address),
    .block_index   (block_index),
    .used_count    (used_count),
    .peak_count    (peak_count)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the configuration registers, as written.
  logic [31:0] cfg_base  = '0;
  logic [31:0] cfg_size  = '0;
  logic [31:0] cfg_count = '0;
  logic [31:0] cfg_len   = '0;

  // Pool state as the allocator should hold it.
  logic [31:0]         pool_base_q  = '0;
  logic [31:0]         pool_size_q  = '0;
  logic [31:0]         pool_count_q = '0;
  logic [POOL_MAX-1:0] busy_map     = '0;
  logic [8:0]          n_used       = '0;
  logic [8:0]          n_peak       = '0;
  bit                  pool_up      = 1'b0;

  // Replies still owed by the allocator, oldest first.
  reply_t pool_replies[$];
  int     mismatches = 0;

  // Idle controls: when set, that side runs without gaps.
  bit send_quiet  = 1'b0;
  bit stall_quiet = 1'b0;
  int stall_hold  = 0;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Work out the reply to one command and advance the pool state.
  task automatic predict_reply(input cmd_t c, input logic [31:0] a, output reply_t r);
    logic [31:0] need;
    logic [31:0] off;
    logic [31:0] idx;
    int          i;
    bit          found;
    r.code     = STAT_OK;
    r.blk_addr = '0;
    r.blk_idx  = '0;
    case (c)
      CMD_INIT: begin
        if (cfg_base == 0 || cfg_size == 0 || cfg_count == 0 || cfg_count > POOL_MAX) begin
          r.code = STAT_INIT_REJ;
        end else begin
          need = cfg_size * cfg_count + (cfg_count + 32'd7) / 32'd8;
          if (cfg_len < need) begin
            r.code = STAT_INIT_REJ;
          end else begin
            pool_base_q  = cfg_base;
            pool_size_q  = cfg_size;
            pool_count_q = cfg_count;
            busy_map     = '0;
            n_used       = '0;
            n_peak       = '0;
            pool_up      = 1'b1;
          end
        end
      end
      CMD_RSVD: r.code = STAT_INIT_REJ;
      default: begin
        if (!pool_up) begin
          r.code = STAT_NOT_INIT;
        end else if (c == CMD_ALLOC) begin
          found = 1'b0;
          for (i = 0; i < pool_count_q && i < POOL_MAX; i++) begin
            if (!busy_map[i]) begin
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            r.code = STAT_FULL;
          end else begin
            busy_map[i] = 1'b1;
            n_used = n_used + 9'd1;
            if (n_used > n_peak) n_peak = n_used;
            r.blk_addr = pool_base_q + 32'(i) * pool_size_q;
            r.blk_idx  = i[7:0];
          end
        end else begin
          // free: the index is compared at full width, never truncated
          off = a - pool_base_q;
          if (a == 0 || pool_size_q == 0 || off % pool_size_q != 0) begin
            r.code = STAT_BAD_ADDR;
          end else begin
            idx = off / pool_size_q;
            if (idx >= pool_count_q || idx >= POOL_MAX) begin
              r.code = STAT_BAD_ADDR;
            end else if (!busy_map[idx]) begin
              r.code = STAT_NOT_ALLOC;
            end else begin
              busy_map[idx] = 1'b0;
              if (n_used > 0) n_used = n_used - 9'd1;
              r.blk_idx = idx[7:0];
            end
          end
        end
      end
    endcase
    r.used = n_used;
    r.peak = n_peak;
  endtask

  // Present one command, hold it until the transfer, then predict its reply.
  // Valid stays high when no gap follows, so the next call simply replaces
  // the payload in the same step.
  task automatic send_cmd(input cmd_t c, input logic [31:0] a);
    reply_t r;
    int     gap;
    in_valid <= 1'b1;
    cmd      <= c;
    address  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reply(c, a, r);
    pool_replies.push_back(r);
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed reply has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pool_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back. The upper half of cfg_data is
  // junk for the 16-bit registers and must be dropped by the block.
  task automatic set_pool(input logic [31:0] base, input logic [15:0] size,
                          input logic [15:0] count, input logic [15:0] len);
    cfg_write <= 1'b1;
    cfg_index <= REG_POOL_BASE;
    cfg_data  <= base;
    cfg_base   = base;
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= {16'($urandom), size};
    cfg_size   = {16'd0, size};
    @(posedge clk);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= {16'($urandom), count};
    cfg_count  = {16'd0, count};
    @(posedge clk);
    cfg_index <= REG_BUFFER_LENGTH;
    cfg_data  <= {16'($urandom), len};
    cfg_len    = {16'd0, len};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Reconfigure from idle and issue an initialize.
  task automatic try_init(input logic [31:0] base, input logic [15:0] size,
                          input logic [15:0] count, input logic [15:0] len);
    wait_idle();
    set_pool(base, size, count, len);
    send_cmd(CMD_INIT, $urandom);
  endtask

  function automatic logic [31:0] slot_addr(input int i);
    return pool_base_q + 32'(i) * pool_size_q;
  endfunction

  function automatic int rand_slot();
    return $urandom_range(0, (pool_count_q == 0) ? 0 : pool_count_q - 1);
  endfunction

  // Address of some allocated block, scanning from a random start.
  function automatic logic [31:0] pick_busy_addr();
    int n;
    int start;
    int j;
    n = (pool_count_q == 0) ? 1 : pool_count_q;
    start = $urandom_range(0, n - 1);
    for (j = 0; j < n; j++) begin
      if (busy_map[(start + j) % n]) return slot_addr((start + j) % n);
    end
    return slot_addr(start);
  endfunction

  // Commands on a pool that has never been initialized.
  task automatic test_before_init();
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    send_cmd(CMD_FREE, 32'h0000_0100);
    send_cmd(CMD_RSVD, 32'h0);
    send_cmd(CMD_INIT, 32'h0);
  endtask

  // Each rejection rule of initialize, then the tightest buffer that passes.
  task automatic test_init_checks();
    try_init(32'h0, 16'd4, 16'd3, 16'd100);
    try_init(32'h1000, 16'd0, 16'd3, 16'd100);
    try_init(32'h1000, 16'd4, 16'd0, 16'd100);
    try_init(32'h1000, 16'd4, 16'(POOL_MAX + 1), 16'hFFFF);
    try_init(32'h1000, 16'd4, 16'd3, 16'd12);
    try_init(32'h1000, 16'd4, 16'd3, 16'd13);
  endtask

  // Three-block pool at 0x1000, 4 bytes each: fill, overflow, bad frees.
  task automatic test_small_pool();
    send_cmd(CMD_ALLOC, $urandom);
    send_cmd(CMD_ALLOC, $urandom);
    send_cmd(CMD_ALLOC, $urandom);
    send_cmd(CMD_ALLOC, $urandom);          // pool full
    send_cmd(CMD_FREE, 32'h0);              // null
    send_cmd(CMD_FREE, 32'h1002);           // misaligned
    send_cmd(CMD_FREE, 32'h100C);           // one past the last block
    send_cmd(CMD_FREE, 32'h0004_1000);      // index only fits if truncated
    send_cmd(CMD_FREE, 32'h0FFC);           // below base, offset wraps
    send_cmd(CMD_FREE, 32'h1004);
    send_cmd(CMD_FREE, 32'h1004);           // already free
    send_cmd(CMD_ALLOC, $urandom);          // takes the hole again
    send_cmd(CMD_RSVD, $urandom);
    send_cmd(CMD_INIT, $urandom);           // re-init while ready
    send_cmd(CMD_FREE, 32'h1000);           // map was cleared
    wait_idle();
  endtask

  // Random traffic on the current pool: mostly allocs and frees of live
  // blocks, with a share of broken frees, re-inits and the unused command.
  task automatic run_pool_traffic(input int n_items, input int alloc_pct);
    int          k;
    int          r;
    int          sub;
    logic [31:0] a;
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_idle();
      if (k % 40 == 0) begin
        send_quiet  = ($urandom_range(0, 4) == 0);
        stall_quiet = ($urandom_range(0, 4) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        send_cmd(CMD_ALLOC, $urandom);
      end else begin
        sub = $urandom_range(0, 19);
        if (sub < 10) begin
          send_cmd(CMD_FREE, pick_busy_addr());
        end else if (sub < 12) begin
          send_cmd(CMD_FREE, slot_addr(rand_slot()));
        end else if (sub == 12) begin
          send_cmd(CMD_FREE, 32'h0);
        end else if (sub < 15) begin
          if (pool_size_q > 1) a = slot_addr(rand_slot()) + $urandom_range(1, pool_size_q - 1);
          else a = $urandom;
          send_cmd(CMD_FREE, a);
        end else if (sub < 17) begin
          if (sub == 15) a = slot_addr(pool_count_q + $urandom_range(0, 3));
          else a = pool_base_q + $urandom * pool_size_q;
          send_cmd(CMD_FREE, a);
        end else if (sub == 17) begin
          send_cmd(CMD_FREE, $urandom);
        end else if (sub == 18) begin
          send_cmd(CMD_INIT, $urandom);
        end else begin
          send_cmd(CMD_RSVD, $urandom);
        end
      end
    end
    send_quiet  = 1'b0;
    stall_quiet = 1'b0;
    wait_idle();
  endtask

  // A run of pool settings: the extremes first, then random, mostly small pools.
  task automatic test_random_pools();
    int          ph;
    int          cnt;
    int          lim;
    int          sz;
    logic [31:0] need;
    logic [31:0] len;
    for (ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin
          // largest pool, one byte each: the full map scan
          try_init($urandom | 32'h1, 16'd1, 16'(POOL_MAX), 16'hFFFF);
          run_pool_traffic(420, 75);
        end
        1: begin
          // single huge block, buffer exactly large enough
          try_init(32'hFFFF_0000, 16'd65534, 16'd1, 16'hFFFF);
          run_pool_traffic(100, 50);
        end
        2: begin
          // base at the top of the address space, addresses wrap
          try_init(32'hFFFF_FFFF, 16'd3, 16'd8, 16'd25);
          run_pool_traffic(120, 55);
        end
        3: begin
          try_init($urandom | 32'h1, 16'd255, 16'(POOL_MAX), 16'hFFFF);
          run_pool_traffic(150, 60);
        end
        4: begin
          // zero base and all-ones settings are rejected; the old pool stays in place
          try_init(32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          run_pool_traffic(60, 50);
        end
        default: begin
          cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(17, POOL_MAX)
                                             : $urandom_range(1, 16);
          lim = (65535 - 32) / cnt;
          if (lim > 64) lim = 64;
          sz   = $urandom_range(1, lim);
          need = 32'(sz) * 32'(cnt) + 32'((cnt + 7) / 8);
          if ($urandom_range(0, 4) == 0) len = need - 1;
          else len = need + $urandom_range(0, 3);
          if (len > 32'hFFFF) len = 32'hFFFF;
          try_init($urandom, 16'(sz), 16'(cnt), len[15:0]);
          run_pool_traffic(130, 50);
        end
      endcase
    end
  endtask

  // Receiver: hold stall high or low for random stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= !stall_quiet && ($urandom_range(0, 99) < 35);
      stall_hold <= pick_gap();
    end
  end

  // Check each result transfer against the oldest owed reply.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pool_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none owed: status %0d addr %h idx %0d",
                   $realtime, status, block_address, block_index);
      end else begin
        want = pool_replies.pop_front();
        if (status !== want.code || block_address !== want.blk_addr ||
            block_index !== want.blk_idx || used_count !== want.used ||
            peak_count !== want.peak) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch (expected/actual): status %0d/%0d addr %h/%h idx %0d/%0d",
                     $realtime, want.code, status, want.blk_addr, block_address,
                     want.blk_idx, block_index);
            $display("%0t:   used %0d/%0d peak %0d/%0d", $realtime, want.used, used_count,
                     want.peak, peak_count);
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_init();
    test_init_checks();
    test_small_pool();
    test_random_pools();
    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pool_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
